@@ rtl/rfs_pkg.sv @@
// Shared types and character constants of the RPC frame field splitter.
`default_nettype none

package rfs_pkg;

    // Characters the parser reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        PH_BEGIN    = 4'd0,
        PH_TYPE     = 4'd1,
        PH_UNIQUE   = 4'd2,
        PH_ACTION   = 4'd3,
        PH_ECODE    = 4'd4,
        PH_EDESC    = 4'd5,
        PH_PAYSTART = 4'd6,
        PH_PAYOBJ   = 4'd7,
        PH_PAYARR   = 4'd8,
        PH_DONE     = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        TAG_NONE    = 3'd0,
        TAG_UID     = 3'd1,
        TAG_ACTION  = 3'd2,
        TAG_ECODE   = 3'd3,
        TAG_EDESC   = 3'd4,
        TAG_PAYLOAD = 3'd5
    } tag_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_CALL    = 2'd1,
        KIND_RESULT  = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_START = 2'd1,
        ERR_TYPE  = 2'd2,
        ERR_NEST  = 2'd3
    } err_t;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] char_in;
        logic       frame_last;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [2:0] field_tag;
        logic [7:0] field_byte;
        logic [1:0] msg_kind;
        logic       frame_end;
        logic       frame_ok;
        logic [1:0] parse_error;
    } out_item_t;

    // Parse state apart from the nesting counter
    typedef struct packed {
        phase_t phase;
        logic   in_quotes;
        kind_t  kind;
        logic   closed_seen;
        err_t   error;
        logic   halted;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_BEGIN,
        in_quotes:   1'b0,
        kind:        KIND_UNKNOWN,
        closed_seen: 1'b0,
        error:       ERR_NONE,
        halted:      1'b0
    };

endpackage

`default_nettype wire

@@ rtl/rfs_parser.sv @@
// Per-byte parse step and the parse state registers of the frame splitter.
`default_nettype none

module rfs_parser
    import rfs_pkg::*;
#(
    parameter int MAX_NESTING = 255
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_en,
    input  wire in_item_t  item,
    output out_item_t      result
);

    localparam int DepthWidth = $clog2(MAX_NESTING + 1);
    localparam logic [DepthWidth-1:0] MaxDepth = DepthWidth'(MAX_NESTING);

    parse_state_t          state_reg, state_next;
    logic [DepthWidth-1:0] depth_reg, depth_next;

    // Step helpers
    logic       txt_on;
    tag_t       txt_tag;
    phase_t     txt_phase;
    logic       txt_keep;
    logic       pay_on;
    logic [7:0] pay_open;
    logic [7:0] pay_close;
    tag_t       tag;
    logic [7:0] ch;
    logic       at_limit;

    assign ch       = item.char_in;
    assign at_limit = (depth_reg >= MaxDepth);

    // One parse step
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        tag        = TAG_NONE;
        txt_on     = 1'b0;
        txt_tag    = TAG_NONE;
        txt_phase  = state_reg.phase;
        txt_keep   = 1'b0;
        pay_on     = 1'b0;
        pay_open   = CH_LBRACE;
        pay_close  = CH_RBRACE;

        if (!state_reg.halted)
        begin
            if (ch == CH_NUL)
            begin
                state_next.halted = 1'b1;
            end
            else
            begin
                unique case (state_reg.phase)
                    PH_BEGIN:
                    begin
                        if (ch == CH_LBRACK)
                        begin
                            state_next.phase = PH_TYPE;
                        end
                        else if (ch != CH_SPACE)
                        begin
                            state_next.error  = ERR_START;
                            state_next.halted = 1'b1;
                        end
                    end
                    PH_TYPE:
                    begin
                        priority if (ch == CH_SPACE)
                        begin
                        end
                        else if (ch == CH_COMMA)
                        begin
                            state_next.phase = PH_UNIQUE;
                        end
                        else if (ch == CH_TWO)
                        begin
                            state_next.kind = KIND_CALL;
                        end
                        else if (ch == CH_THREE)
                        begin
                            state_next.kind = KIND_RESULT;
                        end
                        else if (ch == CH_FOUR)
                        begin
                            state_next.kind = KIND_ERROR;
                        end
                        else
                        begin
                            state_next.error  = ERR_TYPE;
                            state_next.halted = 1'b1;
                        end
                    end
                    PH_UNIQUE:
                    begin
                        txt_on   = 1'b1;
                        txt_tag  = TAG_UID;
                        txt_keep = (state_reg.kind == KIND_UNKNOWN);
                        unique case (state_reg.kind)
                            KIND_CALL:   txt_phase = PH_ACTION;
                            KIND_RESULT: txt_phase = PH_PAYSTART;
                            default:     txt_phase = PH_ECODE;
                        endcase
                    end
                    PH_ACTION:
                    begin
                        txt_on    = 1'b1;
                        txt_tag   = TAG_ACTION;
                        txt_phase = PH_PAYSTART;
                    end
                    PH_ECODE:
                    begin
                        txt_on    = 1'b1;
                        txt_tag   = TAG_ECODE;
                        txt_phase = PH_EDESC;
                    end
                    PH_EDESC:
                    begin
                        txt_on    = 1'b1;
                        txt_tag   = TAG_EDESC;
                        txt_phase = PH_PAYSTART;
                    end
                    PH_PAYSTART:
                    begin
                        if (ch == CH_LBRACE || ch == CH_LBRACK)
                        begin
                            if (at_limit)
                            begin
                                state_next.error  = ERR_NEST;
                                state_next.halted = 1'b1;
                            end
                            else
                            begin
                                depth_next       = depth_reg + 1'b1;
                                state_next.phase = (ch == CH_LBRACE) ? PH_PAYOBJ
                                                                     : PH_PAYARR;
                                tag              = TAG_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYOBJ:
                    begin
                        pay_on    = 1'b1;
                        pay_open  = CH_LBRACE;
                        pay_close = CH_RBRACE;
                    end
                    PH_PAYARR:
                    begin
                        pay_on    = 1'b1;
                        pay_open  = CH_LBRACK;
                        pay_close = CH_RBRACK;
                    end
                    default:
                    begin
                        // after the payload only a closing bracket matters
                        if (ch == CH_RBRACK)
                        begin
                            state_next.closed_seen = 1'b1;
                        end
                    end
                endcase

                // Text fields: quotes toggle, unquoted comma ends the field unless the message kind is still unknown
                if (txt_on)
                begin
                    priority if (!state_reg.in_quotes && ch == CH_SPACE)
                    begin
                    end
                    else if (ch == CH_QUOTE)
                    begin
                        state_next.in_quotes = !state_reg.in_quotes;
                    end
                    else if (!state_reg.in_quotes && ch == CH_COMMA)
                    begin
                        if (!txt_keep)
                        begin
                            state_next.phase = txt_phase;
                        end
                    end
                    else
                    begin
                        tag = txt_tag;
                    end
                end

                // Payload: count only the bracket kind that opened it
                if (pay_on)
                begin
                    if (ch == pay_open && at_limit)
                    begin
                        state_next.error  = ERR_NEST;
                        state_next.halted = 1'b1;
                    end
                    else
                    begin
                        if (ch == pay_open)
                        begin
                            depth_next = depth_reg + 1'b1;
                        end
                        else if (ch == pay_close && depth_reg != '0)
                        begin
                            depth_next = depth_reg - 1'b1;
                        end
                        if (depth_next == '0)
                        begin
                            state_next.phase = PH_DONE;
                        end
                        tag = TAG_PAYLOAD;
                    end
                end
            end
        end

        // Result shows the state after this byte, before any frame clear
        result.field_tag   = tag;
        result.field_byte  = (tag != TAG_NONE) ? ch : 8'h00;
        result.msg_kind    = state_next.kind;
        result.frame_end   = item.frame_last;
        result.frame_ok    = state_next.closed_seen && (state_next.error == ERR_NONE);
        result.parse_error = state_next.error;

        if (item.frame_last)
        begin
            state_next = STATE_RESET;
            depth_next = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            depth_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    // Checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= MaxDepth)
        else $error("nesting depth beyond bound");

    a_payload_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PAYOBJ || state_reg.phase == PH_PAYARR) |-> depth_reg != '0)
        else $error("inside payload with zero depth");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.frame_last) |=> (state_reg == STATE_RESET && depth_reg == '0))
        else $error("state not cleared after last byte of frame");

endmodule

`default_nettype wire

@@ rtl/rpc_frame_field_splitter.sv @@
// RPC frame field splitter top level: input register, parse step, result register.
// A byte transferred in is held in the input register, then parsed on its way into the result register.
// Throughput: one byte per cycle while results are taken; the parse state updates once per byte in a single step.
// A waiting result does not stop intake while the input register is free to move.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to
// the start of a frame; the last byte of each frame does the same to the parse state.
`default_nettype none

module rpc_frame_field_splitter
    import rfs_pkg::*;
#(
    parameter int MAX_NESTING = 255
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    output logic           char_ready,
    input  wire in_item_t  char_item,
    output logic           res_valid,
    input  wire logic      res_ready,
    output out_item_t      res_item
);

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_item_reg;
    out_item_t step_result;
    logic      res_load;

    // Handshake: move the input register on whenever the result slot frees
    assign res_load   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign char_ready = !s1_valid_reg || res_load;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    // Parse step between the two registers
    rfs_parser #(
        .MAX_NESTING (MAX_NESTING)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (res_load),
        .item    (s1_item_reg),
        .result  (step_result)
    );

    // Valid flags next values
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_valid && char_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_load)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            s1_item_reg <= char_item;
        end
        if (res_load)
        begin
            res_item_reg <= step_result;
        end
    end

    // Checks
    a_byte_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.field_tag == TAG_NONE) |-> res_item_reg.field_byte == 8'h00)
        else $error("untagged result carries a byte");

    a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.frame_ok) |-> res_item_reg.parse_error == ERR_NONE)
        else $error("frame ok while an error is set");

    a_error_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.parse_error != ERR_NONE)
            |-> res_item_reg.field_tag == TAG_NONE)
        else $error("byte tagged after a parse error");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (res_valid_reg && res_item_reg.frame_end == $past(s1_item_reg.frame_last)))
        else $error("result register missed a parse step");

endmodule

`default_nettype wire

@@ tb/sv/frame_parse_checker.sv @@
// Checker for the RPC frame field splitter: predicts every result and compares it.
`timescale 1ns / 1ps

module frame_parse_checker
    import rfs_pkg::*;
#(
    parameter int NEST_LIMIT = 255
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    input  wire logic      char_ready,
    input  wire in_item_t  char_item,
    input  wire logic      res_valid,
    input  wire logic      res_ready,
    input  wire out_item_t res_item,
    output int             mismatches,
    output int             results_due,
    output int             results_checked
);

    // Mirrored parser state
    phase_t    phase;
    logic      in_quotes;
    int        nest_level;
    kind_t     kind;
    logic      closed_seen;
    err_t      err;
    logic      halted;

    // Predicted results, oldest first
    out_item_t pending_results[$];

    function automatic void clear_parse();
        phase       = PH_BEGIN;
        in_quotes   = 1'b0;
        nest_level  = 0;
        kind        = KIND_UNKNOWN;
        closed_seen = 1'b0;
        err         = ERR_NONE;
        halted      = 1'b0;
    endfunction

    // Text fields: spaces outside quotes and quotes are dropped, an unquoted comma
    // moves on unless the message kind is still unknown
    function automatic tag_t text_char(logic [7:0] ch, tag_t tag, phase_t nxt, logic hold);
        if (!in_quotes && ch == CH_SPACE)
            return TAG_NONE;
        if (ch == CH_QUOTE)
        begin
            in_quotes = !in_quotes;
            return TAG_NONE;
        end
        if (!in_quotes && ch == CH_COMMA)
        begin
            if (!hold)
                phase = nxt;
            return TAG_NONE;
        end
        return tag;
    endfunction

    // One more bracket level; overflow halts the frame with a nesting error
    function automatic logic open_level();
        if (nest_level >= NEST_LIMIT)
        begin
            err    = ERR_NEST;
            halted = 1'b1;
            return 1'b0;
        end
        nest_level++;
        return 1'b1;
    endfunction

    // Payload body: only the bracket kind that opened it is counted
    function automatic tag_t payload_char(logic [7:0] ch, logic [7:0] opener,
                                          logic [7:0] closer);
        if (ch == opener)
        begin
            if (!open_level())
                return TAG_NONE;
        end
        else if (ch == closer && nest_level > 0)
            nest_level--;
        if (nest_level == 0)
            phase = PH_DONE;
        return TAG_PAYLOAD;
    endfunction

    // Parse one byte, return the result it should produce
    function automatic out_item_t parse_byte(in_item_t item);
        logic [7:0] ch;
        tag_t       tag;
        phase_t     nxt;
        out_item_t  r;
        ch  = item.char_in;
        tag = TAG_NONE;
        if (!halted)
        begin
            if (ch == CH_NUL)
                halted = 1'b1;
            else
            begin
                case (phase)
                    PH_BEGIN:
                    begin
                        if (ch == CH_LBRACK)
                            phase = PH_TYPE;
                        else if (ch != CH_SPACE)
                        begin
                            err    = ERR_START;
                            halted = 1'b1;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (ch == CH_COMMA)
                            phase = PH_UNIQUE;
                        else if (ch == CH_TWO)
                            kind = KIND_CALL;
                        else if (ch == CH_THREE)
                            kind = KIND_RESULT;
                        else if (ch == CH_FOUR)
                            kind = KIND_ERROR;
                        else if (ch != CH_SPACE)
                        begin
                            err    = ERR_TYPE;
                            halted = 1'b1;
                        end
                    end
                    PH_UNIQUE:
                    begin
                        nxt = (kind == KIND_CALL)   ? PH_ACTION :
                              (kind == KIND_RESULT) ? PH_PAYSTART : PH_ECODE;
                        tag = text_char(ch, TAG_UID, nxt, kind == KIND_UNKNOWN);
                    end
                    PH_ACTION:
                        tag = text_char(ch, TAG_ACTION, PH_PAYSTART, 1'b0);
                    PH_ECODE:
                        tag = text_char(ch, TAG_ECODE, PH_EDESC, 1'b0);
                    PH_EDESC:
                        tag = text_char(ch, TAG_EDESC, PH_PAYSTART, 1'b0);
                    PH_PAYSTART:
                    begin
                        if (ch == CH_LBRACE || ch == CH_LBRACK)
                        begin
                            if (open_level())
                            begin
                                phase = (ch == CH_LBRACE) ? PH_PAYOBJ : PH_PAYARR;
                                tag   = TAG_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYOBJ:
                        tag = payload_char(ch, CH_LBRACE, CH_RBRACE);
                    PH_PAYARR:
                        tag = payload_char(ch, CH_LBRACK, CH_RBRACK);
                    default:
                    begin
                        if (ch == CH_RBRACK)
                            closed_seen = 1'b1;
                    end
                endcase
            end
        end
        r.field_tag   = tag;
        r.field_byte  = (tag != TAG_NONE) ? ch : 8'h00;
        r.msg_kind    = kind;
        r.frame_end   = item.frame_last;
        r.frame_ok    = closed_seen && (err == ERR_NONE);
        r.parse_error = err;
        // Verdict goes out with the last byte, then the parser starts afresh
        if (item.frame_last)
            clear_parse();
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Watch both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            clear_parse();
            pending_results.delete();
            mismatches      = 0;
            results_due     = 0;
            results_checked = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                pending_results.push_back(parse_byte(char_item));
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: %0h", res_item);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("field_tag",   want.field_tag,   res_item.field_tag);
                    check_field("field_byte",  want.field_byte,  res_item.field_byte);
                    check_field("msg_kind",    want.msg_kind,    res_item.msg_kind);
                    check_field("frame_end",   want.frame_end,   res_item.frame_end);
                    check_field("frame_ok",    want.frame_ok,    res_item.frame_ok);
                    check_field("parse_error", want.parse_error, res_item.parse_error);
                    results_checked++;
                end
            end
            results_due = pending_results.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the RPC frame field splitter: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import rfs_pkg::*;

    localparam int NEST_LIMIT  = 255;
    localparam int ITEM_TARGET = 1500;
    localparam int DEEP_FRAMES = 3;
    localparam int LONG_HOLD   = 300;

    typedef enum int {
        STYLE_GOOD,
        STYLE_NOISE,
        STYLE_BAD_START,
        STYLE_BAD_TYPE,
        STYLE_ZERO,
        STYLE_DEEP,
        STYLE_COUNT
    } frame_style_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      char_valid = 1'b0;
    in_item_t  char_item  = '0;
    logic      res_ready  = 1'b0;
    logic      char_ready;
    logic      res_valid;
    out_item_t res_item;

    int mismatches;
    int results_due;
    int results_checked;

    in_item_t frame_bytes[$];
    int       bytes_sent  = 0;
    int       frames_sent = 0;
    bit       feed_calm   = 1'b0;

    rpc_frame_field_splitter #(.MAX_NESTING(NEST_LIMIT)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    frame_parse_checker #(.NEST_LIMIT(NEST_LIMIT)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_ready      (char_ready),
        .char_item       (char_item),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_item        (res_item),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame building
    task automatic push_char(logic [7:0] ch);
        frame_bytes.push_back('{char_in: ch, frame_last: 1'b0});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Mostly printable, with separators and the odd arbitrary nonzero byte
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (pick < 14)
            return CH_SPACE;
        else if (pick < 16)
            return CH_COMMA;
        else if (pick < 17)
            return CH_QUOTE;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_field(int maxlen);
        bit quoted;
        quoted = ($urandom_range(0, 3) != 0);
        if (quoted)
            push_char(CH_QUOTE);
        repeat ($urandom_range(0, maxlen))
            push_char(text_byte());
        if (quoted)
            push_char(CH_QUOTE);
    endtask

    // Payload with some nesting of its own bracket kind
    task automatic push_payload();
        logic [7:0] opener;
        logic [7:0] closer;
        int         depth;
        int         pick;
        opener = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK;
        closer = (opener == CH_LBRACE) ? CH_RBRACE : CH_RBRACK;
        push_char(opener);
        depth = 1;
        repeat ($urandom_range(0, 12))
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0 && depth < 5)
            begin
                push_char(opener);
                depth++;
            end
            else if (pick == 1 && depth > 1)
            begin
                push_char(closer);
                depth--;
            end
            else if (pick == 2)
                push_char(CH_QUOTE);
            else
                push_char(text_byte());
        end
        repeat (depth)
            push_char(closer);
    endtask

    // Mostly well-formed frame with random content, sometimes cut short
    task automatic build_good();
        int         n_digits;
        int         keep;
        logic [7:0] digit;
        repeat ($urandom_range(0, 2))
            push_char(CH_SPACE);
        push_char(CH_LBRACK);
        case ($urandom_range(0, 9))
            0:       n_digits = 0;
            1:       n_digits = 2;
            default: n_digits = 1;
        endcase
        digit = CH_TWO;
        repeat (n_digits)
        begin
            digit = CH_TWO + 8'($urandom_range(0, 2));
            push_char(digit);
        end
        if ($urandom_range(0, 3) == 0)
            push_char(CH_SPACE);
        push_char(CH_COMMA);
        push_field(6);
        if (n_digits > 0 && digit != CH_THREE)
        begin
            push_char(CH_COMMA);
            push_field(8);
            if (digit == CH_FOUR)
            begin
                push_char(CH_COMMA);
                push_field(10);
            end
        end
        push_char(CH_COMMA);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                push_char(text_byte());
        push_payload();
        if ($urandom_range(0, 3) != 0)
            push_char(CH_RBRACK);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                push_char(text_byte());
        if ($urandom_range(0, 7) == 0)
        begin
            keep = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > keep)
                void'(frame_bytes.pop_back());
        end
    endtask

    task automatic build_frame(frame_style_t style, int deep_levels);
        logic [7:0] ch;
        case (style)
            STYLE_NOISE:
                repeat ($urandom_range(1, 8))
                    push_char(8'($urandom_range(0, 255)));
            STYLE_BAD_START:
            begin
                repeat ($urandom_range(0, 2))
                    push_char(CH_SPACE);
                do
                    ch = 8'($urandom_range(1, 255));
                while (ch == CH_SPACE || ch == CH_LBRACK);
                push_char(ch);
                repeat ($urandom_range(0, 4))
                    push_char(8'($urandom_range(0, 255)));
            end
            STYLE_BAD_TYPE:
            begin
                push_char(CH_LBRACK);
                if ($urandom_range(0, 2) == 0)
                    push_char(CH_SPACE);
                do
                    ch = 8'($urandom_range(1, 255));
                while (ch == CH_SPACE || ch == CH_COMMA || ch == CH_TWO ||
                       ch == CH_THREE || ch == CH_FOUR);
                push_char(ch);
                repeat ($urandom_range(0, 4))
                    push_char(text_byte());
            end
            STYLE_ZERO:
            begin
                build_good();
                frame_bytes[$urandom_range(0, frame_bytes.size() - 1)].char_in = CH_NUL;
            end
            STYLE_DEEP:
            begin
                push_char(CH_LBRACK);
                push_char(CH_THREE);
                push_char(CH_COMMA);
                push_text("\"u\",");
                repeat (deep_levels)
                    push_char(CH_LBRACK);
                repeat (deep_levels)
                    push_char(CH_RBRACK);
                push_char(CH_RBRACK);
            end
            default:
                build_good();
        endcase
    endtask

    // One byte per transfer, with a random gap in front unless the feed is calm
    task automatic send_byte(in_item_t item);
        int gap;
        if (bytes_sent % 128 == 0)
            feed_calm = ($urandom_range(0, 2) == 0);
        gap = feed_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= item;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        frame_bytes[frame_bytes.size() - 1].frame_last = 1'b1;
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
        frames_sent++;
    endtask

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin
        int taken;
        int gap;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n);
        forever
        begin
            if (taken % 128 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 12);
            if (taken == 200)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        frame_style_t style;
        int           deep_done;
        int           roll;
        deep_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bad start on an all-ones byte
        push_char(8'hFF);
        send_frame();
        // Leading space, then a bad type digit
        push_text(" [5");
        send_frame();
        // Comma while the kind is unknown, then a zero byte halts the frame
        push_text("[,a,");
        push_char(CH_NUL);
        push_text("x");
        send_frame();
        // Two type digits, quoted comma, unquoted space; the braces land in the error description
        push_text("[34,\"a,\" b,c,d{}]");
        send_frame();

        // Random frames: every style once, then weighted towards well-formed ones
        while (bytes_sent < ITEM_TARGET)
        begin
            if (frames_sent < 4 + STYLE_COUNT)
                style = frame_style_t'(frames_sent - 4);
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    style = STYLE_GOOD;
                else if (roll < 70)
                    style = STYLE_NOISE;
                else if (roll < 78)
                    style = STYLE_BAD_START;
                else if (roll < 86)
                    style = STYLE_BAD_TYPE;
                else if (roll < 98)
                    style = STYLE_ZERO;
                else
                    style = STYLE_DEEP;
            end
            if (style == STYLE_DEEP && deep_done >= DEEP_FRAMES)
                style = STYLE_GOOD;
            // First deep frame overflows by one level, later ones sit around the bound
            build_frame(style, (deep_done == 0) ? NEST_LIMIT + 1 :
                        $urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 2));
            if (style == STYLE_DEEP)
                deep_done++;
            send_frame();
        end
        char_valid <= 1'b0;

        // Drain outstanding results, then let the clock idle
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d frames (%0d bytes): well-formed, truncated, malformed, %s",
                 frames_sent, bytes_sent, "zero-terminated and deeply nested");
        $display("Compared %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rfs_pkg.sv
rtl/rfs_parser.sv
rtl/rpc_frame_field_splitter.sv
tb/sv/frame_parse_checker.sv
tb/sv/tb.sv
